@@ rtl/dqws_pkg.sv @@
// Package for the dual queue weighted server: depths, widths, command and
// result codes, and the controller-to-datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
package dqws_pkg;
   localparam int PRIO_DEPTH  = 16;
   localparam int PLAIN_DEPTH = 16;
   localparam int PRIO_AW     = $clog2(PRIO_DEPTH);
   localparam int PLAIN_AW    = $clog2(PLAIN_DEPTH);
   localparam int PRIO_CW     = $clog2(PRIO_DEPTH + 1);
   localparam int PLAIN_CW    = $clog2(PLAIN_DEPTH + 1);

   localparam logic [1:0] CMD_PRIO  = 2'd0;
   localparam logic [1:0] CMD_PLAIN = 2'd1;
   localparam logic [1:0] CMD_SERVE = 2'd2;

   localparam logic [2:0] KIND_ACCEPT = 3'd0;
   localparam logic [2:0] KIND_PLAIN  = 3'd1;
   localparam logic [2:0] KIND_PRIO   = 3'd2;
   localparam logic [2:0] KIND_EMPTY  = 3'd3;
   localparam logic [2:0] KIND_FULL   = 3'd4;

   localparam logic [0:0] CSR_NORMAL   = 1'b0;
   localparam logic [0:0] CSR_FALLBACK = 1'b1;

   typedef struct packed {
      logic       load;       // capture request fields
      logic       ins_step;   // one shift step of the sorted insert
      logic       ins_done;   // write the new priority entry
      logic       plain_push;
      logic       pop_plain;
      logic       pop_prio;
      logic [2:0] kind;       // kind for a status-only result
      logic       emit_stat;
      logic       last;
   } dp_cmd_type;

   typedef struct packed {
      logic prio_empty;
      logic prio_full;
      logic plain_empty;
      logic plain_full;
      logic ins_found;        // slot for the new entry reached
      logic plain_ge_nb;
      logic plain_one;        // exactly one plain entry left
      logic prio_one;
   } dp_stat_type;
endpackage

@@ rtl/dual_queue_weighted_server.sv @@
// Top level of the dual queue weighted server: burst registers, controller
// and datapath. Depends on dqws_pkg, dqws_ctrl and dqws_datapath.
`timescale 1ns / 1ps
// Usage. A request is taken when start is high and busy is low; req_cmd
// selects a priority arrival, a plain arrival or a serve. Every result
// appears on the rsp_ ports for one cycle with rsp_valid high, and rsp_last
// marks the final result of a request. The receiver cannot stall.
// Sequencing. A plain arrival, rejection or empty serve gives its result in the
// cycle after the transfer and the block is free again at once. A priority
// arrival walks the sorted store one entry per cycle from the tail and holds
// the block until the new entry is written. A serve pops one entry per cycle
// and serves at most eight entries.
// Configuration. csr_index 0 writes normal_burst and 1 writes fallback_burst;
// csr_ready is always high, and a value of zero acts as one. Writes belong
// in idle time only.
// Reset. A synchronous reset empties both queues and sets both bursts to 3;
// stored entries are not cleared, since only filled entries are ever read.
module dual_queue_weighted_server import dqws_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_prio_value,
   input  logic [15:0] req_client_tag,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_served_tag,
   output logic [7:0]  rsp_served_prio,
   output logic        rsp_last,
   output logic [4:0]  rsp_prio_count,
   output logic [4:0]  rsp_plain_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [2:0]  csr_data
);
   logic [2:0]  normal_ff, fallback_ff, nb, fb;
   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   // Burst registers; a zero burst behaves as a burst of one.
   always_ff @(posedge clock) begin
      if (reset) begin
         normal_ff   <= 3'd3;
         fallback_ff <= 3'd3;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NORMAL:   normal_ff   <= csr_data;
            CSR_FALLBACK: fallback_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign nb = (normal_ff == 3'd0) ? 3'd1 : normal_ff;
   assign fb = (fallback_ff == 3'd0) ? 3'd1 : fallback_ff;

   dqws_ctrl u_ctrl (
      .clock, .reset, .start, .req_cmd, .nb, .fb, .stat, .busy, .cmd
   );

   dqws_datapath u_dp (
      .clock, .reset, .cmd,
      .prio_value (req_prio_value),
      .client_tag (req_client_tag),
      .nb, .stat, .rsp_valid, .rsp_kind, .rsp_served_tag, .rsp_served_prio,
      .rsp_last, .rsp_prio_count, .rsp_plain_count
   );

`ifndef ASSERT_OFF
   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_prio_count <= 5'(PRIO_DEPTH) && rsp_plain_count <= 5'(PLAIN_DEPTH))
      else $error("queue count out of range");
   a_done: assert property (@(posedge clock) disable iff (reset)
      (busy && !u_ctrl.busy) |-> 1'b0) else $error("busy mismatch");
   a_last_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy) else $error("busy after last result");
   a_plain_tag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_PLAIN) |-> rsp_served_prio == 8'd0)
      else $error("plain result carries a priority");
`endif
endmodule

@@ rtl/dqws_datapath.sv @@
// Datapath: priority store with a one-step-per-cycle sorted insert, plain FIFO,
// and the result register. Depends on dqws_pkg.
`timescale 1ns / 1ps
module dqws_datapath import dqws_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   input  logic [7:0]        prio_value,
   input  logic [15:0]       client_tag,
   input  logic [2:0]        nb,
   output dp_stat_type       stat,
   output logic              rsp_valid,
   output logic [2:0]        rsp_kind,
   output logic [15:0]       rsp_served_tag,
   output logic [7:0]        rsp_served_prio,
   output logic              rsp_last,
   output logic [4:0]        rsp_prio_count,
   output logic [4:0]        rsp_plain_count
);
   logic [23:0] prio_mem_ff [PRIO_DEPTH];
   logic [15:0] plain_mem_ff [PLAIN_DEPTH];
   logic [PRIO_CW-1:0]  prio_fill_ff, prio_fill_in;
   logic [PRIO_CW-1:0]  pos_ff;          // insert scan runs from the tail down
   logic [PLAIN_CW-1:0] plain_fill_ff, plain_fill_in;
   logic [PLAIN_AW-1:0] head_ff, tail_ff;
   logic [7:0]  prio_ff;
   logic [15:0] tag_ff;
   logic        valid_ff;
   logic [2:0]  kind_ff;
   logic [15:0] stag_ff;
   logic [7:0]  sprio_ff;
   logic        last_ff;
   logic [23:0] above;

   assign above = (pos_ff != '0) ? prio_mem_ff[pos_ff[PRIO_AW-1:0] - PRIO_AW'(1)] : '0;

   always_comb begin
      prio_fill_in  = prio_fill_ff;
      plain_fill_in = plain_fill_ff;
      if (cmd.ins_done)   prio_fill_in = prio_fill_ff + PRIO_CW'(1);
      if (cmd.pop_prio)   prio_fill_in = prio_fill_ff - PRIO_CW'(1);
      if (cmd.plain_push) plain_fill_in = plain_fill_ff + PLAIN_CW'(1);
      if (cmd.pop_plain)  plain_fill_in = plain_fill_ff - PLAIN_CW'(1);
   end

   always_comb begin
      stat.prio_empty  = (prio_fill_ff == '0);
      stat.prio_full   = (prio_fill_ff == PRIO_CW'(PRIO_DEPTH));
      stat.plain_empty = (plain_fill_ff == '0);
      stat.plain_full  = (plain_fill_ff == PLAIN_CW'(PLAIN_DEPTH));
      stat.ins_found   = (pos_ff == '0) || (above[23:16] >= prio_ff);
      stat.plain_ge_nb = (plain_fill_ff >= PLAIN_CW'(nb));
      stat.plain_one   = (plain_fill_ff == PLAIN_CW'(1));
      stat.prio_one    = (prio_fill_ff == PRIO_CW'(1));
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         prio_ff <= prio_value;
         tag_ff  <= client_tag;
         pos_ff  <= prio_fill_ff;
      end
      if (cmd.ins_step) begin
         prio_mem_ff[pos_ff[PRIO_AW-1:0]] <= above;
         pos_ff <= pos_ff - PRIO_CW'(1);
      end
      if (cmd.ins_done) prio_mem_ff[pos_ff[PRIO_AW-1:0]] <= {prio_ff, tag_ff};
      if (cmd.pop_prio) begin
         for (int i = 0; i < PRIO_DEPTH - 1; i++) prio_mem_ff[i] <= prio_mem_ff[i + 1];
      end
      // The plain push happens in the transfer cycle, so the tag comes straight
      // from the request port.
      if (cmd.plain_push) plain_mem_ff[tail_ff] <= client_tag;
      kind_ff  <= cmd.kind;
      stag_ff  <= '0;
      sprio_ff <= '0;
      last_ff  <= cmd.last;
      if (cmd.pop_plain) begin
         kind_ff <= KIND_PLAIN;
         stag_ff <= plain_mem_ff[head_ff];
      end
      if (cmd.pop_prio) begin
         kind_ff  <= KIND_PRIO;
         stag_ff  <= prio_mem_ff[0][15:0];
         sprio_ff <= prio_mem_ff[0][23:16];
      end
      if (reset) begin
         prio_fill_ff  <= '0;
         plain_fill_ff <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         valid_ff      <= 1'b0;
      end else begin
         prio_fill_ff  <= prio_fill_in;
         plain_fill_ff <= plain_fill_in;
         valid_ff      <= cmd.emit_stat | cmd.pop_plain | cmd.pop_prio;
         if (cmd.plain_push)
            tail_ff <= (tail_ff == PLAIN_AW'(PLAIN_DEPTH - 1)) ? '0 : tail_ff + PLAIN_AW'(1);
         if (cmd.pop_plain)
            head_ff <= (head_ff == PLAIN_AW'(PLAIN_DEPTH - 1)) ? '0 : head_ff + PLAIN_AW'(1);
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_served_tag  = stag_ff;
   assign rsp_served_prio = sprio_ff;
   assign rsp_last        = last_ff;
   assign rsp_prio_count  = 5'(prio_fill_ff);
   assign rsp_plain_count = 5'(plain_fill_ff);
endmodule

@@ rtl/dqws_ctrl.sv @@
// Controller state machine: decodes a request and sequences inserts and
// serve bursts. Depends on dqws_pkg.
`timescale 1ns / 1ps
module dqws_ctrl import dqws_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  req_cmd,
   input  logic [2:0]  nb,
   input  logic [2:0]  fb,
   input  dp_stat_type stat,
   output logic        busy,
   output dp_cmd_type  cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_INSERT, S_PLAIN_ONLY, S_PLAIN_THEN, S_PRIO_ONE, S_FALLBACK
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       take;

   assign take = start & ~busy;
   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               cmd.load = 1'b1;
               case (req_cmd)
                  CMD_PRIO: begin
                     if (stat.prio_full) begin
                        cmd.emit_stat = 1'b1; cmd.kind = KIND_FULL; cmd.last = 1'b1;
                     end else begin
                        state_in = S_INSERT;
                     end
                  end
                  CMD_PLAIN: begin
                     cmd.emit_stat = 1'b1; cmd.last = 1'b1;
                     if (stat.plain_full) cmd.kind = KIND_FULL;
                     else begin
                        cmd.kind = KIND_ACCEPT; cmd.plain_push = 1'b1;
                     end
                  end
                  CMD_SERVE: begin
                     cnt_in = 3'd1;
                     if (stat.prio_empty && stat.plain_empty) begin
                        cmd.emit_stat = 1'b1; cmd.kind = KIND_EMPTY; cmd.last = 1'b1;
                     end else if (stat.prio_empty) state_in = S_PLAIN_ONLY;
                     else if (stat.plain_ge_nb) state_in = S_PLAIN_THEN;
                     else state_in = S_FALLBACK;
                  end
                  default: ;
               endcase
            end
         end
         S_INSERT: begin
            if (stat.ins_found) begin
               cmd.ins_done = 1'b1; cmd.emit_stat = 1'b1;
               cmd.kind = KIND_ACCEPT; cmd.last = 1'b1;
               state_in = S_IDLE;
            end else cmd.ins_step = 1'b1;
         end
         S_PLAIN_ONLY: begin
            cmd.pop_plain = 1'b1;
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == nb || stat.plain_one) begin
               cmd.last = 1'b1; state_in = S_IDLE;
            end
         end
         S_PLAIN_THEN: begin
            cmd.pop_plain = 1'b1;
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == nb) state_in = S_PRIO_ONE;
         end
         S_PRIO_ONE: begin
            cmd.pop_prio = 1'b1; cmd.last = 1'b1; state_in = S_IDLE;
         end
         S_FALLBACK: begin
            cmd.pop_prio = 1'b1;
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == fb || stat.prio_one) begin
               cmd.last = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 3'd1;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule
